// ===== sv/sbsm_pkg.sv =====
// Package for the serial bank switch mapper.
// Holds request and target codes, the mapper state record and fixed constants.
// No dependencies.
package sbsm_pkg;

    // Bus access kinds
    typedef enum logic [1:0] {
        REQ_CPU_RD = 2'd0,
        REQ_CPU_WR = 2'd1,
        REQ_PPU_RD = 2'd2,
        REQ_PPU_WR = 2'd3
    } req_t;

    // Memory targets of a translated access
    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_PRG_RAM = 2'd1,
        TGT_PRG_ROM = 2'd2,
        TGT_CHR     = 2'd3
    } target_t;

    // Internal register chosen by address bits 14:13 on the fifth serial write
    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR_LO  = 2'd1,
        SEL_CHR_HI  = 2'd2,
        SEL_PRG     = 2'd3
    } reg_sel_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_PRG_BANK_COUNT = 1'b0,
        CFG_CHR_RAM_MODE   = 1'b1
    } cfg_idx_t;

    localparam int OFFSET_W   = 18;
    localparam int PRG_OFS_W  = 14;   // 16K PRG bank
    localparam int CHR_OFS_W  = 12;   // 4K CHR bank
    localparam int SERIAL_LEN = 5;

    localparam logic [4:0] CONTROL_RESET   = 5'h0C;
    localparam logic [4:0] PRG_MODE_FORCE  = 5'h0C;
    localparam logic [4:0] PRG_COUNT_RESET = 5'd2;

    // Mapper state
    typedef struct packed {
        logic [4:0] shift_load;
        logic [2:0] write_count;
        logic [4:0] control;
        logic [4:0] chr_bank_lo;
        logic [4:0] chr_bank_hi;
        logic [4:0] prg_bank;
    } map_state_t;

    // One translated result
    typedef struct packed {
        target_t               target;
        logic [OFFSET_W-1:0]   mem_offset;
        logic                  mem_write;
        logic [7:0]            mem_data;
        logic [1:0]            mirroring;
    } result_t;

endpackage

// ===== sv/sbsm_regs.sv =====
// Mapper state registers: five-bit serial loader and the four bank/control registers.
// Depends on sbsm_pkg.
module sbsm_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [1:0]             req_type,
    input  logic [15:0]            bus_addr,
    input  logic [7:0]             write_data,
    output sbsm_pkg::map_state_t   state,
    output logic [4:0]             control_next
);
    import sbsm_pkg::*;

    map_state_t state_reg;
    map_state_t state_next;
    logic       serial_wr;
    logic [4:0] shift_new;
    logic [2:0] count_new;

    assign serial_wr = advance && (req_t'(req_type) == REQ_CPU_WR) && bus_addr[15];
    assign shift_new = {write_data[0], state_reg.shift_load[4:1]};
    assign count_new = state_reg.write_count + 3'd1;

    // Shift in one bit per serial write, load the target on the fifth; bit 7 resets
    always_comb
    begin
        state_next = state_reg;
        if (serial_wr)
        begin
            if (write_data[7])
            begin
                state_next.shift_load  = '0;
                state_next.write_count = '0;
                state_next.control     = state_reg.control | PRG_MODE_FORCE;
            end
            else if (count_new >= 3'(SERIAL_LEN))
            begin
                state_next.shift_load  = '0;
                state_next.write_count = '0;
                unique case (reg_sel_t'(bus_addr[14:13]))
                    SEL_CONTROL: state_next.control     = shift_new;
                    SEL_CHR_LO:  state_next.chr_bank_lo = shift_new;
                    SEL_CHR_HI:  state_next.chr_bank_hi = shift_new;
                    SEL_PRG:     state_next.prg_bank    = shift_new;
                    default:     state_next.prg_bank    = shift_new;
                endcase
            end
            else
            begin
                state_next.shift_load  = shift_new;
                state_next.write_count = count_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.shift_load  <= '0;
            state_reg.write_count <= '0;
            state_reg.control     <= CONTROL_RESET;
            state_reg.chr_bank_lo <= '0;
            state_reg.chr_bank_hi <= '0;
            state_reg.prg_bank    <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state        = state_reg;
    assign control_next = state_next.control;

endmodule

// ===== sv/sbsm_xlate.sv =====
// Address translation: bus access to target memory, physical offset and write strobe.
// Depends on sbsm_pkg.
module sbsm_xlate (
    input  logic [1:0]             req_type,
    input  logic [15:0]            bus_addr,
    input  logic [7:0]             write_data,
    input  sbsm_pkg::map_state_t   state,
    input  logic [4:0]             control_next,
    input  logic [4:0]             prg_bank_count,
    input  logic                   chr_ram_mode,
    output sbsm_pkg::result_t      result
);
    import sbsm_pkg::*;

    req_t        kind;
    logic [3:0]  last_bank;
    logic [3:0]  prg_bank;
    logic [4:0]  chr_bank;
    logic        prg_upper;
    logic        chr_upper;
    logic [OFFSET_W-1:0] prg_ofs;
    logic [OFFSET_W-1:0] chr_ofs;

    assign kind      = req_t'(req_type);
    assign prg_upper = bus_addr[14];
    assign chr_upper = bus_addr[12];

    // Last PRG bank, clamped to the supported range
    always_comb
    begin
        if (prg_bank_count == 5'd0)
            last_bank = 4'd0;
        else if (prg_bank_count > 5'd16)
            last_bank = 4'd15;
        else
            last_bank = 4'(prg_bank_count - 5'd1);
    end

    // PRG bank select by PRG mode
    always_comb
    begin
        unique case (state.control[3:2])
            2'd0, 2'd1: prg_bank = {state.prg_bank[3:1], prg_upper};
            2'd2:       prg_bank = prg_upper ? state.prg_bank[3:0] : 4'd0;
            2'd3:       prg_bank = prg_upper ? last_bank : state.prg_bank[3:0];
            default:    prg_bank = 4'd0;
        endcase
    end

    // CHR bank select: one 8K window or two 4K windows
    always_comb
    begin
        if (!state.control[4])
            chr_bank = {state.chr_bank_lo[4:1], chr_upper};
        else
            chr_bank = chr_upper ? state.chr_bank_hi : state.chr_bank_lo;
    end

    assign prg_ofs = {prg_bank, bus_addr[PRG_OFS_W-1:0]};
    assign chr_ofs = {1'b0, chr_bank, bus_addr[CHR_OFS_W-1:0]};

    // Decode the access
    always_comb
    begin
        result            = '0;
        result.target     = TGT_NONE;
        result.mirroring  = control_next[1:0];
        if (kind == REQ_CPU_RD || kind == REQ_CPU_WR)
        begin
            if (bus_addr[15:13] == 3'b011)
            begin
                result.target     = TGT_PRG_RAM;
                result.mem_offset = {5'd0, bus_addr[12:0]};
                result.mem_write  = (kind == REQ_CPU_WR);
            end
            else if (bus_addr[15] && kind == REQ_CPU_RD)
            begin
                result.target     = TGT_PRG_ROM;
                result.mem_offset = prg_ofs;
            end
        end
        else if (bus_addr[15:13] == 3'b000)
        begin
            if (kind == REQ_PPU_RD || chr_ram_mode)
            begin
                result.target     = TGT_CHR;
                result.mem_offset = chr_ofs;
                result.mem_write  = (kind == REQ_PPU_WR);
            end
        end
        result.mem_data = result.mem_write ? write_data : 8'd0;
    end

endmodule

// ===== sv/serial_bank_switch_mapper_top.sv =====
// Serial bank switch mapper: top level with input and result registers and config port.
// Depends on sbsm_pkg, sbsm_regs and sbsm_xlate.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one bus access per
//   transaction: req_type, bus_addr, write_data. Response channel
//   (rsp_valid / rsp_stall) returns target, mem_offset, mem_write, mem_data
//   and mirroring for each access, in order, one response per request.
//   Configuration: cfg_valid with cfg_index / cfg_data; cfg_ready is always
//   high. Index 0 is the PRG bank count, index 1 the CHR RAM enable.
//   An accepted access sits in the input register; the translation is then
//   computed and captured in the result register when it advances.
//   Throughput is one access per cycle while rsp_stall is low, set by the
//   single translation pass between the two registers; mapper state is
//   updated in the same pass, so each access sees all earlier ones.
//   When rsp_stall is high a full result register holds, the input register
//   keeps one more access, and req_stall rises only while both are full.
//   Reset clears both valid flags, loads control 0x0C, clears the bank and
//   serial registers, and sets the PRG bank count to 2 and CHR RAM off.
module serial_bank_switch_mapper_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] bus_addr,
    input  logic [7:0]  write_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  target,
    output logic [17:0] mem_offset,
    output logic        mem_write,
    output logic [7:0]  mem_data,
    output logic [1:0]  mirroring,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    import sbsm_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_type_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result_next;
    logic        advance;
    logic        in_load;
    logic [4:0]  prg_count_reg;
    logic        chr_ram_reg;
    map_state_t  state;
    logic [4:0]  control_next;

    // Move the held access into the result register when it is empty or not stalled
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign in_load   = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_load)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_type_reg <= req_type;
            in_addr_reg <= bus_addr;
            in_data_reg <= write_data;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg <= PRG_COUNT_RESET;
            chr_ram_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PRG_BANK_COUNT: prg_count_reg <= cfg_data;
                CFG_CHR_RAM_MODE:   chr_ram_reg   <= cfg_data[0];
                default:            prg_count_reg <= cfg_data;
            endcase
        end
    end

    sbsm_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .req_type     (in_type_reg),
        .bus_addr     (in_addr_reg),
        .write_data   (in_data_reg),
        .state        (state),
        .control_next (control_next)
    );

    sbsm_xlate u_xlate (
        .req_type       (in_type_reg),
        .bus_addr       (in_addr_reg),
        .write_data     (in_data_reg),
        .state          (state),
        .control_next   (control_next),
        .prg_bank_count (prg_count_reg),
        .chr_ram_mode   (chr_ram_reg),
        .result         (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!rsp_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign target     = out_reg.target;
    assign mem_offset = out_reg.mem_offset;
    assign mem_write  = out_reg.mem_write;
    assign mem_data   = out_reg.mem_data;
    assign mirroring  = out_reg.mirroring;

endmodule
